@@ hdl/lrupr_pkg.sv @@
package lrupr_pkg;

    // Defaults for the top-level parameters.
    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    // Fixed widths of the port fields.
    localparam int PAGE_W  = 16;
    localparam int FIDX_W  = 3;
    localparam int FAULT_W = 16;
    localparam int CFG_W   = 4;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Recency ranks saturate at the top of this width.
    localparam int                   RANK_BITS = 8;
    localparam logic [RANK_BITS-1:0] RANK_MAX  = '1;

    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Register map, indexed by paddr[2].
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(8);

    // Status carried by the search token as it walks the cells.
    typedef struct packed {
        logic valid;
        logic hit;
        logic empty;
    } t_flags;

    // Control broadcast to every cell when a reference is committed.
    typedef struct packed {
        logic en;
        logic hit;
    } t_upd;

endpackage

@@ hdl/lrupr_cell.sv @@
module lrupr_cell #(
    parameter int PAGE_BITS = 16,
    parameter int IDX_BITS  = 3,
    parameter int CELL_IDX  = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_active,
    // Search token from the previous cell
    input  lrupr_pkg::t_flags               i_flags,
    input  logic [PAGE_BITS-1:0]            i_page,
    input  logic [IDX_BITS-1:0]             i_hit_idx,
    input  logic [lrupr_pkg::RANK_BITS-1:0] i_hit_rank,
    input  logic [IDX_BITS-1:0]             i_empty_idx,
    input  logic [lrupr_pkg::RANK_BITS-1:0] i_best_rank,
    input  logic [IDX_BITS-1:0]             i_best_idx,
    input  logic [PAGE_BITS-1:0]            i_best_page,
    // Search token to the next cell
    output lrupr_pkg::t_flags               o_flags,
    output logic [PAGE_BITS-1:0]            o_page,
    output logic [IDX_BITS-1:0]             o_hit_idx,
    output logic [lrupr_pkg::RANK_BITS-1:0] o_hit_rank,
    output logic [IDX_BITS-1:0]             o_empty_idx,
    output logic [lrupr_pkg::RANK_BITS-1:0] o_best_rank,
    output logic [IDX_BITS-1:0]             o_best_idx,
    output logic [PAGE_BITS-1:0]            o_best_page,
    // Commit broadcast
    input  lrupr_pkg::t_upd                 i_upd,
    input  logic [IDX_BITS-1:0]             i_upd_slot,
    input  logic [lrupr_pkg::RANK_BITS-1:0] i_upd_limit,
    input  logic [PAGE_BITS-1:0]            i_upd_page
);
    import lrupr_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    // Frame state
    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [RANK_BITS-1:0] r_rank;
    logic [PAGE_BITS-1:0] n_page;
    logic                 n_valid;
    logic [RANK_BITS-1:0] n_rank;

    // Token stage
    t_flags               r_flags,     n_flags;
    logic [PAGE_BITS-1:0] r_tpage,     n_tpage;
    logic [IDX_BITS-1:0]  r_hit_idx,   n_hit_idx;
    logic [RANK_BITS-1:0] r_hit_rank,  n_hit_rank;
    logic [IDX_BITS-1:0]  r_empty_idx, n_empty_idx;
    logic [RANK_BITS-1:0] r_best_rank, n_best_rank;
    logic [IDX_BITS-1:0]  r_best_idx,  n_best_idx;
    logic [PAGE_BITS-1:0] r_best_page, n_best_page;

    always_comb begin
        n_flags     = i_flags;
        n_tpage     = i_page;
        n_hit_idx   = i_hit_idx;
        n_hit_rank  = i_hit_rank;
        n_empty_idx = i_empty_idx;
        n_best_rank = i_best_rank;
        n_best_idx  = i_best_idx;
        n_best_page = i_best_page;
        if (i_active) begin
            if (r_valid && (r_page == i_page) && !i_flags.hit) begin
                n_flags.hit = 1'b1;
                n_hit_idx   = MY_IDX;
                n_hit_rank  = r_rank;
            end
            if (!r_valid && !i_flags.empty) begin
                n_flags.empty = 1'b1;
                n_empty_idx   = MY_IDX;
            end
            // Strictly greater keeps the lowest-numbered frame among equal ranks.
            if ((CELL_IDX == 0) || (r_rank > i_best_rank)) begin
                n_best_rank = r_rank;
                n_best_idx  = MY_IDX;
                n_best_page = r_page;
            end
        end
    end

    always_comb begin
        n_page  = r_page;
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_upd.en && i_active) begin
            if (i_upd_slot == MY_IDX) begin
                n_rank = '0;
                if (!i_upd.hit) begin
                    n_valid = 1'b1;
                    n_page  = i_upd_page;
                end
            end else if (r_valid && (r_rank != RANK_MAX)
                         && (!i_upd.hit || (r_rank < i_upd_limit))) begin
                n_rank = r_rank + RANK_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
            r_flags <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page      <= n_page;
        r_tpage     <= n_tpage;
        r_hit_idx   <= n_hit_idx;
        r_hit_rank  <= n_hit_rank;
        r_empty_idx <= n_empty_idx;
        r_best_rank <= n_best_rank;
        r_best_idx  <= n_best_idx;
        r_best_page <= n_best_page;
    end

    assign o_flags     = r_flags;
    assign o_page      = r_tpage;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_rank  = r_hit_rank;
    assign o_empty_idx = r_empty_idx;
    assign o_best_rank = r_best_rank;
    assign o_best_idx  = r_best_idx;
    assign o_best_page = r_best_page;

endmodule

@@ hdl/lru_page_replacement.sv @@
// LRU page replacement. Each input beat carries one page reference, which is
// checked against the frames taking part in replacement (frames 0 up to
// frames_in_use minus one; a value of 0 acts as 1 and one above FRAMES acts as
// FRAMES). A hit makes that frame most recently used; a miss counts a fault
// (saturating at 65535) and loads the page into the lowest-numbered empty
// frame, or else evicts the least recently used frame, the lowest-numbered one
// where ranks are equal. Each reference gives one result beat with the hit
// flag, the frame used, any evicted page and the fault count. Every frame is a
// cell in a row; a search token carrying the reference walks the row one cell
// per clock. The token passes through all FRAMES cells, its outcome is latched
// and then committed to all cells and the output register; only after that
// commit is the block ready for the next reference. The next reference is
// accepted while a result still waits in the output register, but its commit
// is held back for as long as that earlier result is not taken. frames_in_use
// is written through the APB port at address 0 and reads back there; it should
// only be changed while no reference is in flight. There is no clearing pass
// after reset.
module lru_page_replacement #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lrupr_pkg::APB_AW-1:0]    paddr,
    input  logic [lrupr_pkg::APB_DW-1:0]    pwdata,
    output logic [lrupr_pkg::APB_DW-1:0]    prdata,
    output logic                            pready,
    // Page references
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [lrupr_pkg::PAGE_W-1:0]    i_page,
    // Results
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_hit,
    output logic [lrupr_pkg::FIDX_W-1:0]    o_frame_index,
    output logic                            o_evicted_valid,
    output logic [lrupr_pkg::PAGE_W-1:0]    o_evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]   o_fault_count
);
    import lrupr_pkg::*;

    localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CFG_W-1:0] r_frames_in_use;
    logic [7:0]       w_eff;
    logic [FRAMES-1:0] w_active;
    logic             w_accept;
    logic             w_cfg_wr;
    logic             w_commit;

    // Token chain: entry 0 is the injected reference, entry g+1 leaves cell g.
    t_flags               w_flags     [0:FRAMES];
    logic [PAGE_BITS-1:0] w_page      [0:FRAMES];
    logic [IDX_BITS-1:0]  w_hit_idx   [0:FRAMES];
    logic [RANK_BITS-1:0] w_hit_rank  [0:FRAMES];
    logic [IDX_BITS-1:0]  w_empty_idx [0:FRAMES];
    logic [RANK_BITS-1:0] w_best_rank [0:FRAMES];
    logic [IDX_BITS-1:0]  w_best_idx  [0:FRAMES];
    logic [PAGE_BITS-1:0] w_best_page [0:FRAMES];
    logic [FRAMES-1:0]    w_tok_valid;
    logic [31:0]          w_in_ext;

    // Latched outcome of a search
    logic                 r_tok_hit;
    logic                 r_tok_empty;
    logic [PAGE_BITS-1:0] r_tok_page;
    logic [IDX_BITS-1:0]  r_tok_hit_idx;
    logic [RANK_BITS-1:0] r_tok_hit_rank;
    logic [IDX_BITS-1:0]  r_tok_empty_idx;
    logic [IDX_BITS-1:0]  r_tok_best_idx;
    logic [PAGE_BITS-1:0] r_tok_best_page;

    logic [IDX_BITS-1:0]  w_slot;
    logic                 w_evict;
    logic [31:0]          w_slot_ext;
    logic [31:0]          w_ev_ext;
    t_upd                 w_upd;

    logic [FAULT_W-1:0]   r_faults, n_faults;

    logic                 r_out_valid;
    logic                 r_o_hit;
    logic [FIDX_W-1:0]    r_o_frame_index;
    logic                 r_o_evicted_valid;
    logic [PAGE_W-1:0]    r_o_evicted_page;
    logic [FAULT_W-1:0]   r_o_fault_count;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == REG_FRAMES_IN_USE);
    assign prdata   = (paddr[2] == REG_FRAMES_IN_USE) ? APB_DW'(r_frames_in_use) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FRAMES_IN_USE_RST;
        end else if (w_cfg_wr) begin
            r_frames_in_use <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (r_frames_in_use == '0) begin
            w_eff = 8'd1;
        end else if ({4'b0, r_frames_in_use} > 8'(FRAMES)) begin
            w_eff = 8'(FRAMES);
        end else begin
            w_eff = {4'b0, r_frames_in_use};
        end
    end

    // Sequencing
    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_commit = (r_state == ST_DECIDE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (w_flags[FRAMES].valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (w_commit) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Token injection
    assign w_in_ext       = 32'(i_page);
    assign w_flags[0]     = '{valid: w_accept, hit: 1'b0, empty: 1'b0};
    assign w_page[0]      = w_in_ext[PAGE_BITS-1:0];
    assign w_hit_idx[0]   = '0;
    assign w_hit_rank[0]  = '0;
    assign w_empty_idx[0] = '0;
    assign w_best_rank[0] = '0;
    assign w_best_idx[0]  = '0;
    assign w_best_page[0] = '0;

    // Commit broadcast
    always_comb begin
        if (r_tok_hit) begin
            w_slot = r_tok_hit_idx;
        end else if (r_tok_empty) begin
            w_slot = r_tok_empty_idx;
        end else begin
            w_slot = r_tok_best_idx;
        end
    end

    assign w_evict    = !r_tok_hit && !r_tok_empty;
    assign w_upd      = '{en: w_commit, hit: r_tok_hit};
    assign w_slot_ext = 32'(w_slot);
    assign w_ev_ext   = 32'(r_tok_best_page);

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        assign w_active[g]    = (8'(g) < w_eff);
        assign w_tok_valid[g] = w_flags[g+1].valid;

        lrupr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .IDX_BITS  (IDX_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_active    (w_active[g]),
            .i_flags     (w_flags[g]),
            .i_page      (w_page[g]),
            .i_hit_idx   (w_hit_idx[g]),
            .i_hit_rank  (w_hit_rank[g]),
            .i_empty_idx (w_empty_idx[g]),
            .i_best_rank (w_best_rank[g]),
            .i_best_idx  (w_best_idx[g]),
            .i_best_page (w_best_page[g]),
            .o_flags     (w_flags[g+1]),
            .o_page      (w_page[g+1]),
            .o_hit_idx   (w_hit_idx[g+1]),
            .o_hit_rank  (w_hit_rank[g+1]),
            .o_empty_idx (w_empty_idx[g+1]),
            .o_best_rank (w_best_rank[g+1]),
            .o_best_idx  (w_best_idx[g+1]),
            .o_best_page (w_best_page[g+1]),
            .i_upd       (w_upd),
            .i_upd_slot  (w_slot),
            .i_upd_limit (r_tok_hit_rank),
            .i_upd_page  (r_tok_page)
        );
    end

    // The token leaves the last cell for one cycle only, so catch it here.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SEARCH) && w_flags[FRAMES].valid) begin
            r_tok_hit       <= w_flags[FRAMES].hit;
            r_tok_empty     <= w_flags[FRAMES].empty;
            r_tok_page      <= w_page[FRAMES];
            r_tok_hit_idx   <= w_hit_idx[FRAMES];
            r_tok_hit_rank  <= w_hit_rank[FRAMES];
            r_tok_empty_idx <= w_empty_idx[FRAMES];
            r_tok_best_idx  <= w_best_idx[FRAMES];
            r_tok_best_page <= w_best_page[FRAMES];
        end
    end

    // Fault counter
    always_comb begin
        n_faults = r_faults;
        if (!r_tok_hit && (r_faults != FAULT_MAX)) begin
            n_faults = r_faults + FAULT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_faults <= '0;
        end else if (w_commit) begin
            r_faults <= n_faults;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_o_hit           <= r_tok_hit;
            r_o_frame_index   <= w_slot_ext[FIDX_W-1:0];
            r_o_evicted_valid <= w_evict;
            r_o_evicted_page  <= w_evict ? w_ev_ext[PAGE_W-1:0] : '0;
            r_o_fault_count   <= n_faults;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_frame_index   = r_o_frame_index;
    assign o_evicted_valid = r_o_evicted_valid;
    assign o_evicted_page  = r_o_evicted_page;
    assign o_fault_count   = r_o_fault_count;

    // Checks
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one search token in the cell row");

    a_token_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flags[FRAMES].valid |-> (r_state == ST_SEARCH))
        else $error("search token left the row outside a search");

    a_fault_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_faults != $past(r_faults)))
            |-> $past(w_commit && !r_tok_hit))
        else $error("fault counter moved without a committed miss");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_hit) |-> !r_o_evicted_valid)
        else $error("hit result reports an eviction");

endmodule

@@ test/tb_lru_page_replacement.sv @@
`timescale 1ns / 1ps

module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int NUM_FRAMES  = FRAMES_DEF;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int TAIL_ITEMS  = 30;
    // Frame counts for the random phases, four bits each; the extremes are included.
    localparam logic [PHASES*CFG_W-1:0] PHASE_SETTINGS = {
        4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8, 4'd7, 4'd12, 4'd4, 4'd6
    };

    typedef struct packed {
        logic               hit;
        logic [FIDX_W-1:0]  frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0] fault_count;
    } t_page_outcome;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [APB_AW-1:0]  paddr   = '0;
    logic [APB_DW-1:0]  pwdata  = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [PAGE_W-1:0]  i_page  = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_hit;
    logic [FIDX_W-1:0]  o_frame_index;
    logic               o_evicted_valid;
    logic [PAGE_W-1:0]  o_evicted_page;
    logic [FAULT_W-1:0] o_fault_count;

    // Shadow copy of the frame table and of the register.
    logic [PAGE_W-1:0]    shadow_page  [NUM_FRAMES];
    logic                 shadow_valid [NUM_FRAMES];
    logic [RANK_BITS-1:0] shadow_rank  [NUM_FRAMES];
    logic [FAULT_W-1:0]   shadow_faults;
    logic [CFG_W-1:0]     shadow_frames_in_use;

    logic [PAGE_W-1:0] pending_pages[$];
    t_page_outcome     expected_outcomes[$];
    int                mismatches = 0;
    int                idle_pct   = 0;
    int                send_gap   = 0;
    int                stall_left = 0;

    lru_page_replacement dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_page         (i_page),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_frame_index  (o_frame_index),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_page (o_evicted_page),
        .o_fault_count  (o_fault_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb_lru_page_replacement failed");
        $finish;
    end

    // Works out the result of one reference and updates the shadow table.
    function automatic t_page_outcome predict_reference(input logic [PAGE_W-1:0] pg);
        int            n;
        int            slot;
        int            i;
        bit            found;
        bit            vacant;
        logic [RANK_BITS-1:0] hit_rank;
        t_page_outcome res;
        n      = (shadow_frames_in_use == 0) ? 1 :
                 (shadow_frames_in_use > NUM_FRAMES) ? NUM_FRAMES : int'(shadow_frames_in_use);
        res    = '0;
        slot   = 0;
        found  = 1'b0;
        vacant = 1'b0;
        for (i = 0; i < n; i++) begin
            if (!found && shadow_valid[i] && shadow_page[i] == pg) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            // Only frames younger than the one hit grow older.
            hit_rank = shadow_rank[slot];
            for (i = 0; i < n; i++) begin
                if (shadow_valid[i] && shadow_rank[i] < hit_rank && shadow_rank[i] != RANK_MAX)
                    shadow_rank[i]++;
            end
            shadow_rank[slot] = '0;
        end else begin
            if (shadow_faults != FAULT_MAX)
                shadow_faults++;
            for (i = 0; i < n; i++) begin
                if (!vacant && !shadow_valid[i]) begin
                    slot   = i;
                    vacant = 1'b1;
                end
            end
            if (!vacant) begin
                // Oldest frame goes; on equal ranks the lowest-numbered one.
                slot = 0;
                for (i = 1; i < n; i++) begin
                    if (shadow_rank[i] > shadow_rank[slot])
                        slot = i;
                end
                res.evicted_valid = 1'b1;
                res.evicted_page  = shadow_page[slot];
                shadow_valid[slot] = 1'b0;
            end
            for (i = 0; i < n; i++) begin
                if (shadow_valid[i] && shadow_rank[i] != RANK_MAX)
                    shadow_rank[i]++;
            end
            shadow_page[slot]  = pg;
            shadow_valid[slot] = 1'b1;
            shadow_rank[slot]  = '0;
        end
        res.hit         = found;
        res.frame_index = FIDX_W'(slot);
        res.fault_count = shadow_faults;
        return res;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] word;
        word        = $urandom;
        word[CFG_W-1:0] = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FRAMES_IN_USE, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_frames_in_use = value;
    endtask

    // Returns once every page has been taken and every result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_pages.size() != 0 || i_valid || expected_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Reference driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                expected_outcomes.push_back(predict_reference(i_page));
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_pages.size() != 0) begin
                    i_valid <= 1'b1;
                    i_page  <= pending_pages.pop_front();
                    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                        send_gap = $urandom_range(1, 7);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_page_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, got frame %0d",
                         $time, o_frame_index);
            end else begin
                want = expected_outcomes.pop_front();
                report_field("hit", 32'(want.hit), 32'(o_hit));
                report_field("frame_index", 32'(want.frame_index), 32'(o_frame_index));
                report_field("evicted_valid", 32'(want.evicted_valid), 32'(o_evicted_valid));
                report_field("evicted_page", 32'(want.evicted_page), 32'(o_evicted_page));
                report_field("fault_count", 32'(want.fault_count), 32'(o_fault_count));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        int                p;
        int                k;
        int                pool_size;
        logic [PAGE_W-1:0] pool [16];
        for (k = 0; k < NUM_FRAMES; k++) begin
            shadow_page[k]  = '0;
            shadow_valid[k] = 1'b0;
            shadow_rank[k]  = '0;
        end
        shadow_faults        = '0;
        shadow_frames_in_use = FRAMES_IN_USE_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill all eight frames with extreme patterns, hit some, then force an eviction.
        pending_pages = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000,
                          16'h00FF, 16'hFF00, 16'h0000, 16'hFFFF, 16'h1234, 16'h1234,
                          16'h5555};
        wait_drained();
        // A count of zero behaves as one frame.
        write_frames_in_use(4'd0);
        pending_pages = '{16'h0000, 16'hFFFF, 16'hFFFF};
        wait_drained();
        // Raising the count exposes a duplicate page and leaves ranks tied.
        write_frames_in_use(4'd15);
        pending_pages = '{16'hFFFF, 16'h4321, 16'h0000, 16'h7FFF, 16'hAAAA};
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            write_frames_in_use(PHASE_SETTINGS[p*CFG_W +: CFG_W]);
            // Mix of steady and bursty traffic; the closing phases run flat out.
            idle_pct  = (p >= PHASES - 2) ? 0 : (p % 3 == 0) ? 0 : (p % 3 == 1) ? 15 : 40;
            pool_size = $urandom_range(2, 14);
            for (k = 0; k < pool_size; k++)
                pool[k] = PAGE_W'($urandom_range(0, 65535));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) < 8)
                    pending_pages.push_back(pool[$urandom_range(0, pool_size - 1)]);
                else
                    pending_pages.push_back(PAGE_W'($urandom_range(0, 65535)));
            end
            wait_drained();
        end

        // With one frame every new page faults and evicts the one before it.
        idle_pct = 0;
        write_frames_in_use(4'd1);
        for (k = 0; k < TAIL_ITEMS; k++)
            pending_pages.push_back(PAGE_W'(k));
        wait_drained();

        if (mismatches == 0) begin
            $display("tb_lru_page_replacement passed");
        end else begin
            $display("tb_lru_page_replacement failed");
        end
        $finish;
    end

endmodule
